/* rtl/sshs_pkg.sv */
// Shared constants, keyword table and record type for the section header scanner.
package sshs_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int COUNT_BITS  = 16;

	localparam int REC_RAW_W = 3 + 32 + 32 + OFFSET_BITS + 2 * COUNT_BITS;
	localparam int REC_OUT_W = ((REC_RAW_W + 7) / 8) * 8;

	localparam logic [2:0] KIND_INIT      = 3'd0;
	localparam logic [2:0] KIND_FRAME     = 3'd1;
	localparam logic [2:0] KIND_MACRO     = 3'd2;
	localparam logic [2:0] KIND_TRIGGER   = 3'd3;
	localparam logic [2:0] KIND_DUP_INIT  = 3'd4;
	localparam logic [2:0] KIND_DUP_FRAME = 3'd5;
	localparam logic [2:0] KIND_END       = 3'd6;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_NL    = 8'h0a;
	localparam logic [7:0] CHR_OPEN  = 8'h7b;
	localparam logic [7:0] CHR_CLOSE = 8'h7d;

	localparam logic [1:0] KW_INIT    = 2'd0;
	localparam logic [1:0] KW_FRAME   = 2'd1;
	localparam logic [1:0] KW_MACRO   = 2'd2;
	localparam logic [1:0] KW_TRIGGER = 2'd3;

	typedef struct packed {
		logic                   valid;
		logic [2:0]             kind;
		logic [31:0]            sum_all;
		logic [31:0]            sum_odd;
		logic [OFFSET_BITS-1:0] offset;
		logic [COUNT_BITS-1:0]  macros;
		logic [COUNT_BITS-1:0]  triggers;
	} sshs_rec_t;

	// keyword text: init}, frame}, macro:, trigger:
	function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
		logic [63:0] txt;
		begin
			case (kw)
				KW_INIT:    txt = {8'h00, 8'h00, 8'h00, "}tini"};
				KW_FRAME:   txt = {8'h00, 8'h00, "}emarf"};
				KW_MACRO:   txt = {8'h00, 8'h00, ":orcam"};
				default:    txt = ":reggirt";
			endcase
			kw_char = txt[{idx, 3'b000} +: 8];
		end
	endfunction

	function automatic logic [3:0] kw_len(input logic [1:0] kw);
		begin
			case (kw)
				KW_INIT:  kw_len = 4'd5;
				KW_FRAME: kw_len = 4'd6;
				KW_MACRO: kw_len = 4'd6;
				default:  kw_len = 4'd8;
			endcase
		end
	endfunction

endpackage

/* rtl/sshs_core.sv */
// Scanner state and per-byte update: header matching, name sums, counts.
module sshs_core
	import sshs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_in,
	output sshs_rec_t  rec
);

	localparam logic [2:0] PH_IDLE         = 3'd0;
	localparam logic [2:0] PH_AFTER_NL     = 3'd1;
	localparam logic [2:0] PH_KEYWORD      = 3'd2;
	localparam logic [2:0] PH_MACRO_NAME   = 3'd3;
	localparam logic [2:0] PH_TRIGGER_NAME = 3'd4;

	logic [2:0]             phase_q, phase_d;
	logic [2:0]             kw_idx_q, kw_idx_d;
	logic [3:0]             cand_q, cand_d;
	logic [31:0]            sum_all_q, sum_all_d;
	logic [31:0]            sum_odd_q, sum_odd_d;
	logic                   odd_q, odd_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_next;
	logic                   init_seen_q, init_seen_d;
	logic                   frame_seen_q, frame_seen_d;
	logic [COUNT_BITS-1:0]  macros_q, macros_d;
	logic [COUNT_BITS-1:0]  triggers_q, triggers_d;
	logic                   err_q, err_d;

	logic [3:0] alive;
	logic [3:0] done;
	logic [3:0] idx_inc;

	assign pos_next = pos_q + 1'b1;
	assign idx_inc  = {1'b0, kw_idx_q} + 4'd1;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			alive[c] = cand_q[c] && ({1'b0, kw_idx_q} < kw_len(2'(c)))
				&& (kw_char(2'(c), kw_idx_q) == data_in);
			done[c]  = alive[c] && (kw_len(2'(c)) == idx_inc);
		end
	end

	always_comb begin
		phase_d      = phase_q;
		kw_idx_d     = kw_idx_q;
		cand_d       = cand_q;
		sum_all_d    = sum_all_q;
		sum_odd_d    = sum_odd_q;
		odd_d        = odd_q;
		pos_d        = pos_next;
		init_seen_d  = init_seen_q;
		frame_seen_d = frame_seen_q;
		macros_d     = macros_q;
		triggers_d   = triggers_q;
		err_d        = err_q;

		rec          = '0;
		rec.macros   = macros_q;
		rec.triggers = triggers_q;

		if (data_in == CHR_NUL) begin
			// end of buffer: report counts, then back to reset state
			rec.valid    = 1'b1;
			rec.kind     = KIND_END;
			phase_d      = PH_IDLE;
			kw_idx_d     = '0;
			cand_d       = 4'hf;
			sum_all_d    = '0;
			sum_odd_d    = '0;
			odd_d        = 1'b0;
			pos_d        = '0;
			init_seen_d  = 1'b0;
			frame_seen_d = 1'b0;
			macros_d     = '0;
			triggers_d   = '0;
			err_d        = 1'b0;
		end else if (!err_q) begin
			if (phase_q == PH_MACRO_NAME || phase_q == PH_TRIGGER_NAME) begin
				if (data_in == CHR_CLOSE) begin
					rec.valid   = 1'b1;
					rec.sum_all = sum_all_q;
					rec.sum_odd = sum_odd_q;
					rec.offset  = pos_next;
					if (phase_q == PH_MACRO_NAME) begin
						rec.kind = KIND_MACRO;
						if (macros_q != '1)
							macros_d = macros_q + 1'b1;
					end else begin
						rec.kind = KIND_TRIGGER;
						if (triggers_q != '1)
							triggers_d = triggers_q + 1'b1;
					end
					rec.macros   = macros_d;
					rec.triggers = triggers_d;
					phase_d      = PH_IDLE;
				end else begin
					sum_all_d = sum_all_q + {24'd0, data_in};
					if (odd_q)
						sum_odd_d = sum_odd_q + {24'd0, data_in};
					odd_d = ~odd_q;
				end
			end else if (phase_q == PH_KEYWORD && alive != 4'd0) begin
				cand_d   = alive;
				kw_idx_d = idx_inc[2:0];
				if (done[KW_INIT] || done[KW_FRAME]) begin
					rec.valid  = 1'b1;
					rec.offset = pos_next;
					phase_d    = PH_IDLE;
					if (done[KW_INIT]) begin
						rec.kind    = init_seen_q ? KIND_DUP_INIT : KIND_INIT;
						err_d       = init_seen_q;
						init_seen_d = 1'b1;
					end else begin
						rec.kind     = frame_seen_q ? KIND_DUP_FRAME : KIND_FRAME;
						err_d        = frame_seen_q;
						frame_seen_d = 1'b1;
					end
				end else if (done[KW_MACRO] || done[KW_TRIGGER]) begin
					phase_d   = done[KW_MACRO] ? PH_MACRO_NAME : PH_TRIGGER_NAME;
					sum_all_d = '0;
					sum_odd_d = '0;
					odd_d     = 1'b0;
				end
			end else if (phase_q == PH_AFTER_NL && data_in == CHR_OPEN) begin
				phase_d  = PH_KEYWORD;
				kw_idx_d = '0;
				cand_d   = 4'hf;
			end else begin
				// ordinary byte, including a keyword mismatch
				phase_d = (data_in == CHR_NL) ? PH_AFTER_NL : PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			kw_idx_q     <= '0;
			cand_q       <= 4'hf;
			sum_all_q    <= '0;
			sum_odd_q    <= '0;
			odd_q        <= 1'b0;
			pos_q        <= '0;
			init_seen_q  <= 1'b0;
			frame_seen_q <= 1'b0;
			macros_q     <= '0;
			triggers_q   <= '0;
			err_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			kw_idx_q     <= kw_idx_d;
			cand_q       <= cand_d;
			sum_all_q    <= sum_all_d;
			sum_odd_q    <= sum_odd_d;
			odd_q        <= odd_d;
			pos_q        <= pos_d;
			init_seen_q  <= init_seen_d;
			frame_seen_q <= frame_seen_d;
			macros_q     <= macros_d;
			triggers_q   <= triggers_d;
			err_q        <= err_d;
		end
	end

endmodule

/* rtl/script_section_header_scanner.sv */
// Script section header scanner: one text byte in, at most one header record out, per
// transaction. The block takes one byte every cycle while its output is not stalled; each
// byte goes into an input register, is scanned by a short state update while it is held
// there, and its record, if any, lands in the output register when the byte moves on.
// Input and output stall independently: a byte is accepted whenever the input register is
// empty or moving on, and the output register holds a record until it is taken. A zero
// byte ends the buffer with an end record carrying the macro and trigger counts.
module script_section_header_scanner
	import sshs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [7:0] data_in
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [REC_OUT_W-1:0] m_tdata   // record_kind, name_sum, odd_name_sum, body_offset,
	                                       // macro_count, trigger_count, then zero fill
);

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       advance;
	sshs_rec_t  rec;
	logic       out_valid_q;
	sshs_rec_t  out_rec_q;

	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_tready)
			in_valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			in_byte_s1 <= s_tdata;
	end

	sshs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.data_in (in_byte_s1),
		.rec     (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= rec.valid;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_rec_q <= rec;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = REC_OUT_W'({out_rec_q.triggers, out_rec_q.macros, out_rec_q.offset,
		out_rec_q.sum_odd, out_rec_q.sum_all, out_rec_q.kind});

endmodule
